// ===== rtl/brm_pkg.sv =====
// Package: shared width constants, command struct and controller states.
`timescale 1ns / 1ps

package brm_pkg;

  // Operand width; product is twice this.
  localparam int WIDTH = 8;
  localparam int PROD_W = 2 * WIDTH;
  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;  // capture operands, clear accumulator
    logic step;  // one Booth add/sub and shift pass
  } brm_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } brm_state_t;

endpackage

// ===== rtl/brm_datapath.sv =====
// Datapath: accumulator, shifting multiplier and Booth add/subtract unit.
`timescale 1ns / 1ps

module brm_datapath (
  input  logic                              clk,
  input  brm_pkg::brm_cmd_t                 cmd,
  input  logic signed [brm_pkg::WIDTH-1:0]  multiplicand,
  input  logic signed [brm_pkg::WIDTH-1:0]  multiplier,
  output logic signed [brm_pkg::PROD_W-1:0] product
);
  import brm_pkg::*;

  logic signed [WIDTH:0]   acc;
  logic signed [WIDTH:0]   acc_next;
  logic signed [WIDTH:0]   mcand;
  logic        [WIDTH-1:0] q;
  logic        [WIDTH-1:0] q_next;
  logic                    qprev;
  logic                    qprev_next;
  logic signed [WIDTH:0]   sum;

  // Booth recoding of {q0, q_-1}
  always_comb begin
    case ({q[0], qprev})
      2'b10:   sum = acc - mcand;
      2'b01:   sum = acc + mcand;
      default: sum = acc;
    endcase
  end

  always_comb begin
    acc_next   = acc;
    q_next     = q;
    qprev_next = qprev;
    if (cmd.load) begin
      acc_next   = '0;
      q_next     = multiplier;
      qprev_next = 1'b0;
    end else if (cmd.step) begin
      // arithmetic right shift of sum:q
      acc_next   = {sum[WIDTH], sum[WIDTH:1]};
      q_next     = {sum[0], q[WIDTH-1:1]};
      qprev_next = q[0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mcand <= {multiplicand[WIDTH-1], multiplicand};
    end
    acc   <= acc_next;
    q     <= q_next;
    qprev <= qprev_next;
  end

  assign product = {acc[WIDTH-1:0], q};

endmodule

// ===== rtl/brm_controller.sv =====
// Controller: state machine and pass counter for the sequential multiply.
`timescale 1ns / 1ps

module brm_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output logic              done,
  output brm_pkg::brm_cmd_t cmd
);
  import brm_pkg::*;

  brm_state_t       state;
  brm_state_t       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             last_pass;

  assign last_pass = (cnt == CNT_W'(WIDTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    busy       = 1'b0;
    done       = 1'b0;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        busy     = 1'b1;
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (last_pass) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // result shown this cycle; a new transaction may start at once
        done = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_RUN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/booth_radix2_multiplier.sv =====
// Top level: sequential radix-2 Booth signed multiplier.
`timescale 1ns / 1ps

// Channel  | Ports                        | Handshake
// ---------+------------------------------+-------------------------------
// input    | multiplicand, multiplier     | accepted when start && !busy
// result   | product                      | valid for one cycle with done
//
// Each transaction runs in order: the accept edge loads the operands,
// WIDTH passes follow (one add/sub and shift each, set by the pass counter
// and the single Booth adder), and done pulses in the following cycle.
// A new transaction may be accepted in the done cycle, but not while busy.
// rst is synchronous, active high, and returns the controller to idle.
// The receiver cannot stall: product is only meaningful while done is high.

module booth_radix2_multiplier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [brm_pkg::WIDTH-1:0]  multiplicand,
  input  logic signed [brm_pkg::WIDTH-1:0]  multiplier,
  output logic                              done,
  output logic signed [brm_pkg::PROD_W-1:0] product
);
  import brm_pkg::*;

  // command bundle from controller to datapath
  brm_cmd_t cmd;

  brm_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // accumulator is WIDTH+1 bits so the most negative square is exact
  brm_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .multiplicand (multiplicand),
    .multiplier   (multiplier),
    .product      (product)
  );

endmodule

// ===== rtl/brm_checker.sv =====
// Checker: port-level assertions for the Booth multiplier, bound to the top.
`timescale 1ns / 1ps

module brm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic signed [brm_pkg::WIDTH-1:0]  multiplicand,
  input logic signed [brm_pkg::WIDTH-1:0]  multiplier,
  input logic                              done,
  input logic signed [brm_pkg::PROD_W-1:0] product
);
  import brm_pkg::*;

  localparam int LAT = WIDTH + 1;

  // result follows every accepted transaction
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("done missing after accepted transaction");

  // product matches the operands captured at the accept edge
  a_product: assert property (@(posedge clk) disable iff (rst)
    done |-> product ==
      ({{WIDTH{$past(multiplicand[WIDTH-1], LAT)}}, $past(multiplicand, LAT)} *
       {{WIDTH{$past(multiplier[WIDTH-1], LAT)}}, $past(multiplier, LAT)}))
    else $error("wrong product");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without a start");

endmodule

bind booth_radix2_multiplier brm_checker u_brm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .multiplicand (multiplicand),
  .multiplier   (multiplier),
  .done         (done),
  .product      (product)
);
